FILE: hw/rtl/keyframe_redundancy_filter_defines.svh
// assertion macros shared by the keyframe filter rtl
// no dependencies; the including module must have i_clk and i_rst_n
`ifndef KEYFRAME_REDUNDANCY_FILTER_DEFINES_SVH
`define KEYFRAME_REDUNDANCY_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define KRF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("keyframe filter check failed");
`define KRF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("keyframe filter check failed");
`else
`define KRF_ASSERT_IMPL(lbl, ante, cons)
`define KRF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/krf_pkg.sv
// types and constants of the keyframe redundancy filter
// no dependencies
package krf_pkg;

    localparam int WORD_W             = 32;
    localparam int NUM_VALUES         = 4;
    localparam int MAX_VALUE_SIZE_DEF = 4;
    localparam int DATA_W             = WORD_W * (NUM_VALUES + 1);
    localparam int FIFO_DEPTH         = 4;
    localparam int CFG_IDX_W          = 8;
    localparam int CFG_DATA_W         = 8;
    localparam int VSIZE_W            = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_SIZE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_MODE = 8'd1;

    // where the held key sits in the track
    typedef enum logic [1:0] {
        POS_NONE,
        POS_FIRST,
        POS_SECOND,
        POS_LATER
    } t_key_pos;

    typedef struct packed {
        logic [WORD_W-1:0]                 key_time;
        logic [NUM_VALUES-1:0][WORD_W-1:0] values;
        logic                              track_end;
    } t_key;

    typedef struct packed {
        logic [WORD_W-1:0]                 out_time;
        logic [NUM_VALUES-1:0][WORD_W-1:0] out_values;
        logic                              out_end;
    } t_result;

    // results of one item, first always written before second
    typedef struct packed {
        logic [1:0] cnt;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

FILE: hw/rtl/krf_decide.sv
// track state and keep/drop decision for one keyframe per cycle while i_fire is high
// depends on krf_pkg and keyframe_redundancy_filter_defines.svh
`include "keyframe_redundancy_filter_defines.svh"

module krf_decide
    import krf_pkg::*;
#(
    parameter int MAX_VALUE_SIZE = MAX_VALUE_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  t_key               i_key,
    input  logic [VSIZE_W-1:0] i_value_size,
    input  logic               i_smooth_mode,
    output t_push              o_push
);

    t_key_pos                              r_pos;
    t_key_pos                              n_pos;
    logic [WORD_W-1:0]                     r_held_time;
    logic [WORD_W-1:0]                     r_first_time;
    logic [MAX_VALUE_SIZE-1:0][WORD_W-1:0] r_held_values;
    logic [MAX_VALUE_SIZE-1:0][WORD_W-1:0] r_older_values;

    logic [NUM_VALUES-1:0][WORD_W-1:0]     w_held_ext;
    logic [NUM_VALUES-1:0][WORD_W-1:0]     w_new_ext;
    logic [VSIZE_W-1:0]                    w_used;
    logic                                  w_diff;
    logic                                  w_keep;
    logic                                  w_emit_held;
    t_result                               w_held_res;
    t_result                               w_new_res;

    // elements beyond the stored ones read as zero
    for (genvar g = 0; g < NUM_VALUES; g++) begin : g_ext
        if (g < MAX_VALUE_SIZE) begin : g_on
            assign w_held_ext[g] = r_held_values[g];
            assign w_new_ext[g]  = i_key.values[g];
        end else begin : g_off
            assign w_held_ext[g] = '0;
            assign w_new_ext[g]  = '0;
        end
    end

    assign w_used = (i_value_size > VSIZE_W'(MAX_VALUE_SIZE)) ?
                    VSIZE_W'(MAX_VALUE_SIZE) : i_value_size;

    // any used element differing from either neighbor
    always_comb begin
        w_diff = 1'b0;
        for (int j = 0; j < MAX_VALUE_SIZE; j++) begin
            if ((VSIZE_W'(j) < w_used) &&
                ((r_held_values[j] != r_older_values[j]) ||
                 (r_held_values[j] != i_key.values[j]))) begin
                w_diff = 1'b1;
            end
        end
    end

    // middle key survives on distinct times and changing values, or on distinct times alone in smooth mode
    assign w_keep = (r_held_time != i_key.key_time) &&
                    !((r_pos == POS_SECOND) && (r_held_time == r_first_time)) &&
                    (i_smooth_mode || w_diff);

    // next state
    always_comb begin
        n_pos = r_pos;
        if (i_key.track_end) begin
            n_pos = POS_NONE;
        end else begin
            case (r_pos)
                POS_NONE:  n_pos = POS_FIRST;
                POS_FIRST: n_pos = POS_SECOND;
                default:   n_pos = POS_LATER;
            endcase
        end
    end

    // results of the current item
    always_comb begin
        case (r_pos)
            POS_NONE:   w_emit_held = 1'b0;
            POS_FIRST:  w_emit_held = 1'b1;
            default:    w_emit_held = w_keep;
        endcase
        w_held_res.out_time   = r_held_time;
        w_held_res.out_values = w_held_ext;
        w_held_res.out_end    = 1'b0;
        w_new_res.out_time    = i_key.key_time;
        w_new_res.out_values  = w_new_ext;
        w_new_res.out_end     = 1'b1;
        o_push.cnt    = i_fire ? (2'(w_emit_held) + 2'(i_key.track_end)) : 2'd0;
        o_push.first  = w_emit_held ? w_held_res : w_new_res;
        o_push.second = w_new_res;
    end

    // position register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_NONE;
        end else if (i_fire) begin
            r_pos <= n_pos;
        end
    end

    // held and older keys
    always_ff @(posedge i_clk) begin
        if (i_fire && !i_key.track_end) begin
            if (r_pos == POS_NONE) begin
                r_first_time <= i_key.key_time;
            end
            r_held_time    <= i_key.key_time;
            r_older_values <= r_held_values;
            for (int j = 0; j < MAX_VALUE_SIZE; j++) begin
                r_held_values[j] <= i_key.values[j];
            end
        end
    end

    `KRF_ASSERT_NEXT(a_end_clears_pos, i_fire && i_key.track_end, r_pos == POS_NONE)
    `KRF_ASSERT_IMPL(a_two_only_at_end, o_push.cnt == 2'd2, i_key.track_end)

endmodule

FILE: hw/rtl/krf_out_fifo.sv
// result queue taking up to two items a cycle, giving one when the reader is ready
// depends on krf_pkg and keyframe_redundancy_filter_defines.svh
`include "keyframe_redundancy_filter_defines.svh"

module krf_out_fifo
    import krf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_result              r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W:0]       w_fill;
    logic                 w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && i_ready;
    assign o_room  = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign w_fill  = {1'b0, r_count} + (CNT_W + 1)'(i_push.cnt);
    assign n_count = r_count + CNT_W'(i_push.cnt) - CNT_W'(w_pop);

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push.cnt);
            r_rd_ptr <= r_rd_ptr + PTR_W'(w_pop);
            r_count  <= n_count;
        end
    end

    // storage, second item goes one slot after the first
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_push.second;
        end
    end

    `KRF_ASSERT_IMPL(a_no_overflow, i_push.cnt != 2'd0, w_fill <= (CNT_W + 1)'(FIFO_DEPTH))
    `KRF_ASSERT_NEXT(a_pop_drains, w_pop && (i_push.cnt == 2'd0), r_count == $past(r_count) - 1'b1)

endmodule

FILE: hw/rtl/keyframe_redundancy_filter.sv
// keyframe redundancy filter top: each item passes the input register and the result queue to the output,
// one input item per cycle sustained; a track end item may give two results,
// and input stalls only when the four-entry result queue has fewer than two free slots.
// synchronous active-low reset empties the queue, forgets any held key,
// and sets value_size to 1 and smooth_mode to 0.
// depends on krf_pkg, krf_decide, krf_out_fifo
module keyframe_redundancy_filter
    import krf_pkg::*;
#(
    parameter int MAX_VALUE_SIZE = MAX_VALUE_SIZE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [DATA_W-1:0]     i_s_tdata,  // key_time, value_0, value_1, value_2, value_3
    input  logic                  i_s_tlast,  // track_end
    // result item stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [DATA_W-1:0]     o_m_tdata,  // out_time, out_value_0 .. out_value_3
    output logic                  o_m_tlast,  // out_end
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic               r_in_valid;
    t_key               r_in;
    logic [VSIZE_W-1:0] r_value_size;
    logic               r_smooth_mode;
    logic               w_room;
    logic               w_fire;
    t_push              w_push;
    t_result            w_out;

    assign o_cfg_ready = 1'b1;
    assign w_fire      = r_in_valid && w_room;
    assign o_s_tready  = !r_in_valid || w_fire;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_size  <= VSIZE_W'(1);
            r_smooth_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VALUE_SIZE:  r_value_size  <= i_cfg_data[VSIZE_W-1:0];
                REG_SMOOTH_MODE: r_smooth_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.key_time  <= i_s_tdata[WORD_W-1:0];
            r_in.track_end <= i_s_tlast;
            for (int j = 0; j < NUM_VALUES; j++) begin
                r_in.values[j] <= i_s_tdata[WORD_W*(j+1) +: WORD_W];
            end
        end
    end

    krf_decide #(
        .MAX_VALUE_SIZE(MAX_VALUE_SIZE)
    ) u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_key        (r_in),
        .i_value_size (r_value_size),
        .i_smooth_mode(r_smooth_mode),
        .o_push       (w_push)
    );

    krf_out_fifo u_out_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .o_room (w_room),
        .o_valid(o_m_tvalid),
        .i_ready(i_m_tready),
        .o_data (w_out)
    );

    // result packing
    always_comb begin
        o_m_tdata[WORD_W-1:0] = w_out.out_time;
        for (int j = 0; j < NUM_VALUES; j++) begin
            o_m_tdata[WORD_W*(j+1) +: WORD_W] = w_out.out_values[j];
        end
    end
    assign o_m_tlast = w_out.out_end;

endmodule

FILE: tb/tb_keyframe_redundancy_filter.sv
// self-checking testbench for keyframe_redundancy_filter: directed tracks, then
// random tracks under every value size and both smooth settings, with random gaps on both streams
// depends on krf_pkg and keyframe_redundancy_filter
`timescale 1ns / 100ps

module tb_keyframe_redundancy_filter;
    import krf_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_ITEMS   = 60;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNMAPPED = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNMAPPED  = {CFG_IDX_W{1'b1}};

    // float patterns that stress raw-bit compares
    localparam logic [WORD_W-1:0] FP_POS_ZERO = 32'h0000_0000;
    localparam logic [WORD_W-1:0] FP_NEG_ZERO = 32'h8000_0000;
    localparam logic [WORD_W-1:0] FP_QNAN     = 32'h7FC0_0000;
    localparam logic [WORD_W-1:0] FP_ONES     = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] FP_SPECIAL [4] = '{FP_POS_ZERO, FP_NEG_ZERO, FP_QNAN, FP_ONES};

    // tracks the filter state and holds the kept keys still to come out
    class kept_key_scoreboard;
        t_result                           kept_q[$];
        int                                errors      = 0;
        logic [VSIZE_W-1:0]                value_size  = 3'd1;
        logic                              smooth_mode = 1'b0;
        logic [WORD_W-1:0]                 held_time   = '0;
        logic [WORD_W-1:0]                 first_time  = '0;
        logic [NUM_VALUES-1:0][WORD_W-1:0] held_vals   = '0;
        logic [NUM_VALUES-1:0][WORD_W-1:0] older_vals  = '0;
        t_key_pos                          key_pos     = POS_NONE;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_VALUE_SIZE) begin
                value_size = data[VSIZE_W-1:0];
            end else if (idx == REG_SMOOTH_MODE) begin
                smooth_mode = data[0];
            end
        endfunction

        function void queue_kept(logic [WORD_W-1:0] t,
                                 logic [NUM_VALUES-1:0][WORD_W-1:0] vals, logic last);
            t_result r;
            r.out_time   = t;
            r.out_values = vals;
            r.out_end    = last;
            kept_q.push_back(r);
        endfunction

        // one accepted input item: decide on the held key, then hold the new one
        function void accept_key(t_key k);
            int   used;
            logic keep;
            used = (value_size > MAX_VALUE_SIZE_DEF) ? MAX_VALUE_SIZE_DEF : value_size;
            keep = 1'b0;
            if (key_pos == POS_NONE) begin
                if (k.track_end) begin
                    queue_kept(k.key_time, k.values, 1'b1);
                    return;
                end
                first_time = k.key_time;
            end else if (key_pos == POS_FIRST) begin
                keep = 1'b1;
            end else if (held_time != k.key_time &&
                         !(key_pos == POS_SECOND && held_time == first_time)) begin
                if (smooth_mode) begin
                    keep = 1'b1;
                end else begin
                    for (int j = 0; j < NUM_VALUES; j++) begin
                        if (j < used && (held_vals[j] != older_vals[j] ||
                                         held_vals[j] != k.values[j])) begin
                            keep = 1'b1;
                        end
                    end
                end
            end
            if (keep) begin
                queue_kept(held_time, held_vals, 1'b0);
            end
            if (key_pos != POS_NONE && k.track_end) begin
                queue_kept(k.key_time, k.values, 1'b1);
                key_pos = POS_NONE;
                return;
            end
            older_vals = held_vals;
            held_vals  = k.values;
            held_time  = k.key_time;
            case (key_pos)
                POS_NONE:  key_pos = POS_FIRST;
                POS_FIRST: key_pos = POS_SECOND;
                default:   key_pos = POS_LATER;
            endcase
        endfunction

        // one accepted result item against the oldest kept key
        function void check_kept(t_result got);
            t_result want;
            if (kept_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, none pending: time %h end %b",
                         $time, got.out_time, got.out_end);
                return;
            end
            want = kept_q.pop_front();
            if (got.out_time != want.out_time) begin
                errors++;
                $display("%0t: out_time expected %h actual %h",
                         $time, want.out_time, got.out_time);
            end
            for (int j = 0; j < NUM_VALUES; j++) begin
                if (got.out_values[j] != want.out_values[j]) begin
                    errors++;
                    $display("%0t: out_value_%0d expected %h actual %h",
                             $time, j, want.out_values[j], got.out_values[j]);
                end
            end
            if (got.out_end != want.out_end) begin
                errors++;
                $display("%0t: out_end expected %b actual %b",
                         $time, want.out_end, got.out_end);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [DATA_W-1:0]     i_s_tdata   = '0;
    logic                  i_s_tlast   = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [DATA_W-1:0]     o_m_tdata;
    logic                  o_m_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    bit src_gapless  = 1'b0;
    bit sink_gapless = 1'b0;

    kept_key_scoreboard sb;

    keyframe_redundancy_filter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_key mk_key(logic [WORD_W-1:0] t, logic [WORD_W-1:0] v0,
                                    logic [WORD_W-1:0] v1, logic [WORD_W-1:0] v2,
                                    logic [WORD_W-1:0] v3, logic last);
        t_key k;
        k.key_time  = t;
        k.values    = {v3, v2, v1, v0};
        k.track_end = last;
        return k;
    endfunction

    // next key of a track: times and values often repeat the previous key
    function automatic t_key next_key(t_key prev, bit first);
        t_key k;
        bit   copy_all;
        k = prev;
        if (first) begin
            k.key_time = $urandom();
        end else begin
            case ($urandom_range(0, 7))
                0:       k.key_time = prev.key_time;
                1:       k.key_time = $urandom();
                default: k.key_time = prev.key_time + $urandom_range(1, 1000);
            endcase
        end
        copy_all = !first && ($urandom_range(0, 2) == 0);
        for (int j = 0; j < NUM_VALUES; j++) begin
            if (!copy_all) begin
                case ($urandom_range(0, 7))
                    0, 1, 2, 3: k.values[j] = prev.values[j];
                    4:          k.values[j] = FP_SPECIAL[2'($urandom_range(0, 3))];
                    default:    k.values[j] = $urandom();
                endcase
            end
        end
        return k;
    endfunction

    // input stream driver
    task automatic send_key(input t_key k);
        int gap;
        gap = src_gapless ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {k.values, k.key_time};
        i_s_tlast  <= k.track_end;
        do @(posedge i_clk); while (!o_s_tready);
        sb.accept_key(k);
    endtask

    // random tracks; a track cut by the item count runs on into the next phase
    task automatic send_tracks(input int n_items);
        t_key k;
        t_key prev;
        int   left;
        int   len;
        bit   cut;
        left = n_items;
        prev = '0;
        while (left > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: unrelated key with a random end flag
                k.key_time = $urandom();
                for (int j = 0; j < NUM_VALUES; j++) k.values[j] = $urandom();
                k.track_end = 1'($urandom_range(0, 1));
                send_key(k);
                prev = k;
                left--;
            end else begin
                len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
                cut = (len > left);
                if (cut) len = left;
                for (int i = 0; i < len; i++) begin
                    k = next_key(prev, i == 0);
                    k.track_end = (i == len - 1) && !cut;
                    send_key(k);
                    prev = k;
                end
                left -= len;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // stop sending and wait for every kept key plus pipeline slack
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.kept_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result stream sink with random back-pressure
    initial begin
        int      stall;
        t_result got;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = sink_gapless ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            got.out_time   = o_m_tdata[WORD_W-1:0];
            got.out_values = o_m_tdata[DATA_W-1:WORD_W];
            got.out_end    = o_m_tlast;
            sb.check_kept(got);
        end
    end

    // main sequence
    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed tracks at reset settings: one element compared, smooth off
        // single-key tracks at both extremes
        send_key(mk_key('1, '1, '1, '1, '1, 1'b1));
        send_key(mk_key('0, '0, '0, '0, '0, 1'b1));
        // two keys: the end item gives two results
        send_key(mk_key(32'h3F80_0000, 32'h1111_1111, 32'h2222_2222,
                        32'h3333_3333, 32'h4444_4444, 1'b0));
        send_key(mk_key(32'h4000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                        32'hAAAA_AAAA, 32'h5555_5555, 1'b1));
        // middle key equal in the used element, differing in an unused one
        send_key(mk_key(32'd10, 32'd5, 32'd0, 32'd0, 32'd0, 1'b0));
        send_key(mk_key(32'd20, 32'd5, 32'd9, 32'd8, 32'd7, 1'b0));
        send_key(mk_key(32'd30, 32'd5, 32'd0, 32'd0, 32'd0, 1'b1));
        // held key time equal to the next key time
        send_key(mk_key(32'd10, 32'd1, 32'd0, 32'd0, 32'd0, 1'b0));
        send_key(mk_key(32'd20, 32'd2, 32'd0, 32'd0, 32'd0, 1'b0));
        send_key(mk_key(32'd20, 32'd3, 32'd0, 32'd0, 32'd0, 1'b1));
        // second key time equal to the first key time
        send_key(mk_key(32'd7, 32'd1, 32'd0, 32'd0, 32'd0, 1'b0));
        send_key(mk_key(32'd7, 32'd2, 32'd0, 32'd0, 32'd0, 1'b0));
        send_key(mk_key(32'd9, 32'd3, 32'd0, 32'd0, 32'd0, 1'b0));
        send_key(mk_key(32'd11, 32'd4, 32'd0, 32'd0, 32'd0, 1'b1));
        // minus zero differs from plus zero
        send_key(mk_key(32'd1, FP_POS_ZERO, '0, '0, '0, 1'b0));
        send_key(mk_key(32'd2, FP_NEG_ZERO, '0, '0, '0, 1'b0));
        send_key(mk_key(32'd3, FP_POS_ZERO, '0, '0, '0, 1'b1));
        // identical nan patterns compare equal
        send_key(mk_key(32'd1, FP_QNAN, '0, '0, '0, 1'b0));
        send_key(mk_key(32'd2, FP_QNAN, '0, '0, '0, 1'b0));
        send_key(mk_key(32'd3, FP_QNAN, '0, '0, '0, 1'b1));
        settle();

        // random phases over value sizes 0..7 and both smooth settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            src_gapless  = (p % 4 == 1) || (p % 4 == 3);
            sink_gapless = (p % 4 == 2) || (p % 4 == 3);
            write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNMAPPED, REG_LAST_UNMAPPED)),
                      CFG_DATA_W'($urandom_range(0, 255)));
            write_reg(REG_VALUE_SIZE, CFG_DATA_W'(p % 8));
            write_reg(REG_SMOOTH_MODE, (p % 3 == 2) ? 8'd1 : 8'd0);
            i_cfg_valid <= 1'b0;
            send_tracks(PHASE_ITEMS);
            settle();
        end

        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
